@@ rtl/core/assert_macros.svh @@
// Assertion helpers shared by the core RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

@@ rtl/core/cpca_pkg.sv @@
package cpca_pkg;

   localparam int OP_W   = 2;
   localparam int LEN_W  = 4;
   localparam int HIST_W = 10;
   localparam int CODE_W = 16;
   localparam int OUT_W  = 15;

   localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
   localparam logic [OP_W-1:0] OP_COUNT  = 2'd1;
   localparam logic [OP_W-1:0] OP_ASSIGN = 2'd2;

   typedef enum logic [5:0] {
      ST_IDLE      = 6'b000001,
      ST_COUNT_WR  = 6'b000010,
      ST_PREP_RD   = 6'b000100,
      ST_PREP_WR   = 6'b001000,
      ST_ASSIGN_RD = 6'b010000,
      ST_ASSIGN_WR = 6'b100000
   } state_type;

endpackage

@@ rtl/core/cpca_ram.sv @@
module cpca_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/core/canonical_prefix_code_assign.sv @@
// Count reads a histogram entry, then writes it back. Assign reads the code
// table, then writes back, waiting while the result register holds a stalled
// output. The first assign after a clear or count first sweeps the lengths, a
// histogram read and a code write per length, plus one code table read. A
// result is registered and appears the cycle after the write-back. Reset
// empties the histogram via per-entry valid bits and drops the prepared flag.
`include "assert_macros.svh"

module canonical_prefix_code_assign #(
   parameter int MAX_CODE_BITS = 15
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [cpca_pkg::OP_W-1:0]     req_op,
   input  logic [cpca_pkg::LEN_W-1:0]    req_code_length,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [cpca_pkg::OUT_W-1:0]    rsp_code,
   output logic [cpca_pkg::LEN_W-1:0]    rsp_code_bits
);

   import cpca_pkg::*;

   localparam int DEPTH = MAX_CODE_BITS + 1;
   localparam int IW    = $clog2(DEPTH);
   localparam logic [LEN_W-1:0] MaxLen  = LEN_W'(MAX_CODE_BITS);
   localparam logic [IW-1:0]    LastIdx = IW'(MAX_CODE_BITS);
   localparam logic [IW-1:0]    OneIdx  = IW'(1);

   state_type         state_ff, state_in;
   logic [IW-1:0]     len_ff, len_in;
   logic [IW-1:0]     idx_ff, idx_in;
   logic [CODE_W-1:0] run_code_ff, run_code_in;
   logic              prepared_ff, prepared_in;
   logic [DEPTH-1:0]  hist_valid_ff, hist_valid_in;
   logic              hist_rd_valid_ff, hist_rd_valid_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [OUT_W-1:0]  rsp_code_ff, rsp_code_in;
   logic [LEN_W-1:0]  rsp_code_bits_ff, rsp_code_bits_in;

   logic              accept;
   logic              out_free;
   logic [LEN_W-1:0]  eff_len;
   logic [IW-1:0]     req_idx;
   logic [HIST_W-1:0] prev_count;
   logic [CODE_W-1:0] keep;

   logic              hist_rd_en, hist_wr_en;
   logic [IW-1:0]     hist_rd_addr;
   logic [HIST_W-1:0] hist_wr_data, hist_rdata;
   logic              next_rd_en, next_wr_en;
   logic [IW-1:0]     next_rd_addr, next_wr_addr;
   logic [CODE_W-1:0] next_wr_data, next_rdata;

   cpca_ram #(.WIDTH(HIST_W), .DEPTH(DEPTH)) u_hist_ram (
      .clock   (clock),
      .wr_en   (hist_wr_en),
      .wr_addr (len_ff),
      .wr_data (hist_wr_data),
      .rd_en   (hist_rd_en),
      .rd_addr (hist_rd_addr),
      .rd_data (hist_rdata)
   );

   cpca_ram #(.WIDTH(CODE_W), .DEPTH(DEPTH)) u_next_ram (
      .clock   (clock),
      .wr_en   (next_wr_en),
      .wr_addr (next_wr_addr),
      .wr_data (next_wr_data),
      .rd_en   (next_rd_en),
      .rd_addr (next_rd_addr),
      .rd_data (next_rdata)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign eff_len   = (req_code_length > MaxLen) ? '0 : req_code_length;
   assign req_idx   = eff_len[IW-1:0];
   assign keep      = (CODE_W'(1) << len_ff) - CODE_W'(1);
   assign prev_count = (idx_ff == OneIdx || !hist_rd_valid_ff) ? '0 : hist_rdata;

   always_comb begin
      state_in         = state_ff;
      len_in           = len_ff;
      idx_in           = idx_ff;
      run_code_in      = run_code_ff;
      prepared_in      = prepared_ff;
      hist_valid_in    = hist_valid_ff;
      rsp_code_in      = rsp_code_ff;
      rsp_code_bits_in = rsp_code_bits_ff;
      rsp_valid_in     = rsp_valid_ff && rsp_stall;
      hist_rd_en       = 1'b0;
      hist_rd_addr     = req_idx;
      hist_wr_en       = 1'b0;
      hist_wr_data     = (hist_rd_valid_ff ? hist_rdata : '0) + HIST_W'(1);
      next_rd_en       = 1'b0;
      next_rd_addr     = req_idx;
      next_wr_en       = 1'b0;
      next_wr_addr     = len_ff;
      next_wr_data     = next_rdata + CODE_W'(1);

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               len_in = req_idx;
               case (req_op)
                  OP_CLEAR: begin
                     hist_valid_in = '0;
                     prepared_in   = 1'b0;
                  end
                  OP_COUNT: begin
                     hist_rd_en  = 1'b1;
                     prepared_in = 1'b0;
                     state_in    = ST_COUNT_WR;
                  end
                  OP_ASSIGN: begin
                     if (prepared_ff) begin
                        next_rd_en = 1'b1;
                        state_in   = ST_ASSIGN_WR;
                     end else begin
                        idx_in      = OneIdx;
                        run_code_in = '0;
                        state_in    = ST_PREP_RD;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_COUNT_WR: begin
            hist_wr_en            = 1'b1;
            hist_valid_in[len_ff] = 1'b1;
            state_in              = ST_IDLE;
         end
         ST_PREP_RD: begin
            hist_rd_en   = 1'b1;
            hist_rd_addr = idx_ff - OneIdx;
            state_in     = ST_PREP_WR;
         end
         ST_PREP_WR: begin
            next_wr_en   = 1'b1;
            next_wr_addr = idx_ff;
            next_wr_data = (run_code_ff + CODE_W'(prev_count)) << 1;
            run_code_in  = next_wr_data;
            idx_in       = idx_ff + OneIdx;
            if (idx_ff == LastIdx) begin
               prepared_in = 1'b1;
               state_in    = ST_ASSIGN_RD;
            end else begin
               state_in = ST_PREP_RD;
            end
         end
         ST_ASSIGN_RD: begin
            next_rd_en   = 1'b1;
            next_rd_addr = len_ff;
            state_in     = ST_ASSIGN_WR;
         end
         ST_ASSIGN_WR: begin
            if (out_free) begin
               rsp_valid_in     = 1'b1;
               rsp_code_in      = next_rdata[OUT_W-1:0] & keep[OUT_W-1:0];
               rsp_code_bits_in = LEN_W'(len_ff);
               next_wr_en       = (len_ff != '0);
               state_in         = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      hist_rd_valid_in = hist_rd_en ? hist_valid_ff[hist_rd_addr] : hist_rd_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         prepared_ff      <= 1'b0;
         hist_valid_ff    <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff         <= state_in;
         prepared_ff      <= prepared_in;
         hist_valid_ff    <= hist_valid_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
      len_ff           <= len_in;
      idx_ff           <= idx_in;
      run_code_ff      <= run_code_in;
      hist_rd_valid_ff <= hist_rd_valid_in;
      rsp_code_ff      <= rsp_code_in;
      rsp_code_bits_ff <= rsp_code_bits_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_code      = rsp_code_ff;
   assign rsp_code_bits = rsp_code_bits_ff;

   `ASSERT_NEXT(a_clear_empties, clock, reset, accept && req_op == OP_CLEAR, hist_valid_ff == '0)
   `ASSERT_IMPLIES(a_assign_prepared, clock, reset, state_ff == ST_ASSIGN_WR, prepared_ff)
   `ASSERT_NEXT(a_prep_done, clock, reset, state_ff == ST_PREP_WR && idx_ff == LastIdx, prepared_ff && state_ff == ST_ASSIGN_RD)
   `ASSERT_NEXT(a_result_out, clock, reset, state_ff == ST_ASSIGN_WR && out_free, rsp_valid_ff)

endmodule
